>>> design/udpt_pkg.sv
// Package for the UDP port table engine: item structs, status and command codes,
// register indexes and reset values of the configuration registers.
// Depends on nothing; the top level and udpt_ctrl import it.
package udpt_pkg;

    // Command codes carried in the cmd field of an input item.
    localparam logic [1:0] CMD_BIND   = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes carried in the status field of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IN_USE    = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;
    localparam logic [1:0] ST_NOT_BOUND = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic       REG_EPH_LOW = 1'b0;
    localparam logic       REG_EPH_END = 1'b1;
    localparam logic [15:0] EPH_LOW_RST = 16'd32768;
    localparam logic [15:0] EPH_END_RST = 16'd60999;

    // One table entry: valid bit on top of an 8-bit owner.
    localparam int ENTRY_W = 9;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [7:0]  owner;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] port_out;
        logic [7:0]  owner_out;
    } t_out_item;

endpackage

>>> design/udp_port_table_engine.sv
// Top level of the UDP port table engine: configuration registers, owner
// reduction table, sequencer and port table memory.
// Depends on udpt_pkg, udpt_ctrl and udpt_ram.
//
//   channel   signals                          handshake
//   -------   ------------------------------   ----------------------------
//   command   i_start, o_busy, i_item          taken when i_start && !o_busy
//   result    o_done, o_result                 o_done high for one cycle
//   config    i_cfg_we, i_cfg_idx, i_cfg_data  written when i_cfg_we is high
//
// After reset the table is cleared one entry per cycle, every entry in turn,
// with o_busy high; configuration writes are taken meanwhile.
// Lookup, free and explicit bind read the entry of the port, then check it and
// write it back; an item answered without a read is answered from idle.
// An automatic bind checks candidate ports, lowest first, until one is free.
// Results cannot be stalled: each one is shown for exactly one cycle.
module udp_port_table_engine #(
    parameter int PORT_COUNT  = 65536,
    parameter int OWNER_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  udpt_pkg::t_in_item  i_item,
    output logic                o_done,
    output udpt_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import udpt_pkg::*;

    localparam int AW = $clog2(PORT_COUNT);

    logic [15:0]        r_eph_low;
    logic [15:0]        r_eph_end;
    logic [7:0]         w_mod_tbl [256];
    logic [7:0]         w_owner_st;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eph_low <= EPH_LOW_RST;
            r_eph_end <= EPH_END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EPH_LOW: r_eph_low <= i_cfg_data;
                REG_EPH_END: r_eph_end <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Constant table reducing an owner modulo the owner count.
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tbl[g] = 8'(g % OWNER_COUNT);
    end
    assign w_owner_st = w_mod_tbl[i_item.owner];

    // Sequencer.
    udpt_ctrl #(
        .PORT_COUNT (PORT_COUNT),
        .AW         (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .i_owner_st (w_owner_st),
        .i_eph_low  (r_eph_low),
        .i_eph_end  (r_eph_end),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    // Port table memory.
    udpt_ram #(
        .DEPTH (PORT_COUNT),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

>>> design/udpt_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Holds the port table entries; depends on nothing.
module udpt_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/udpt_ctrl.sv
// Sequencer of the port table engine: clearing pass, read-modify-write of one
// entry per command, and the one-entry-per-cycle search for a free port.
// Depends on udpt_pkg; drives the ports of udpt_ram.
module udpt_ctrl #(
    parameter int PORT_COUNT = 65536,
    parameter int AW         = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  udpt_pkg::t_in_item       i_item,
    input  logic [7:0]               i_owner_st,
    input  logic [15:0]              i_eph_low,
    input  logic [15:0]              i_eph_end,
    output logic                     o_busy,
    output logic                     o_done,
    output udpt_pkg::t_out_item      o_result,
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic [udpt_pkg::ENTRY_W-1:0] o_wdata,
    output logic [AW-1:0]            o_raddr,
    input  logic [udpt_pkg::ENTRY_W-1:0] i_rdata
);
    import udpt_pkg::*;

    localparam logic [16:0]   PORT_LIM = 17'(PORT_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PORT_COUNT - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_SCAN} t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_cmd, n_cmd;
    logic [15:0] r_port, n_port;
    logic [7:0]  r_owner, n_owner;
    logic [16:0] r_scan, n_scan;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_done, n_done;
    t_out_item   r_result, n_result;

    logic [16:0] w_first;
    logic        w_first_ok;
    logic        w_port_ok;
    logic [16:0] w_next;
    logic        w_next_ok;
    logic        w_valid;

    // Start of the automatic search; port zero is never a candidate.
    assign w_first    = (i_eph_low == 16'd0) ? 17'd1 : {1'b0, i_eph_low};
    assign w_first_ok = (w_first < {1'b0, i_eph_end}) && (w_first < PORT_LIM);
    assign w_port_ok  = ({1'b0, i_item.port} < PORT_LIM);
    assign w_next     = r_scan + 17'd1;
    assign w_next_ok  = (w_next < {1'b0, i_eph_end}) && (w_next < PORT_LIM);
    assign w_valid    = i_rdata[ENTRY_W-1];

    // Next-state and memory access logic.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_port   = r_port;
        n_owner  = r_owner;
        n_scan   = r_scan;
        n_clr    = r_clr;
        n_done   = 1'b0;
        n_result = r_result;
        o_we     = 1'b0;
        o_waddr  = r_scan[AW-1:0];
        o_wdata  = '0;
        o_raddr  = i_item.port[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_item.cmd;
                    n_port  = i_item.port;
                    n_owner = i_owner_st;
                    case (i_item.cmd)
                        CMD_BIND: begin
                            if (i_item.port == 16'd0) begin
                                if (w_first_ok) begin
                                    o_raddr = w_first[AW-1:0];
                                    n_scan  = w_first;
                                    n_state = S_SCAN;
                                end else begin
                                    n_done   = 1'b1;
                                    n_result = '{ST_NO_FREE, 16'd0, 8'd0};
                                end
                            end else if (w_port_ok) begin
                                n_state = S_READ;
                            end else begin
                                n_done   = 1'b1;
                                n_result = '{ST_IN_USE, i_item.port, 8'd0};
                            end
                        end
                        CMD_FREE, CMD_LOOKUP: begin
                            if (w_port_ok) begin
                                n_state = S_READ;
                            end else begin
                                n_done   = 1'b1;
                                n_result = '{ST_NOT_BOUND, i_item.port, 8'd0};
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{ST_NOT_BOUND, i_item.port, 8'd0};
                        end
                    endcase
                end
            end
            S_READ: begin
                // Entry of the requested port arrives from the table.
                n_state = S_IDLE;
                n_done  = 1'b1;
                o_waddr = r_port[AW-1:0];
                case (r_cmd)
                    CMD_BIND: begin
                        if (w_valid) begin
                            n_result = '{ST_IN_USE, r_port, 8'd0};
                        end else begin
                            o_we     = 1'b1;
                            o_wdata  = {1'b1, r_owner};
                            n_result = '{ST_OK, r_port, r_owner};
                        end
                    end
                    CMD_FREE: begin
                        if (w_valid) begin
                            o_we     = 1'b1;
                            n_result = '{ST_OK, r_port, i_rdata[7:0]};
                        end else begin
                            n_result = '{ST_NOT_BOUND, r_port, 8'd0};
                        end
                    end
                    default: begin
                        if (w_valid) begin
                            n_result = '{ST_OK, r_port, i_rdata[7:0]};
                        end else begin
                            n_result = '{ST_NOT_BOUND, r_port, 8'd0};
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // One candidate port checked per cycle, lowest first.
                if (!w_valid) begin
                    o_we     = 1'b1;
                    o_waddr  = r_scan[AW-1:0];
                    o_wdata  = {1'b1, r_owner};
                    n_done   = 1'b1;
                    n_result = '{ST_OK, r_scan[15:0], r_owner};
                    n_state  = S_IDLE;
                end else if (w_next_ok) begin
                    o_raddr = w_next[AW-1:0];
                    n_scan  = w_next;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{ST_NO_FREE, 16'd0, 8'd0};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_cmd    <= n_cmd;
        r_port   <= n_port;
        r_owner  <= n_owner;
        r_scan   <= n_scan;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
